>>> design/assert_macros.svh
// assertion macros shared by the rtl files
// needs clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define JSU_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("jsu assertion failed");
`define JSU_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("jsu forbidden condition seen");
`else
`define JSU_ASSERT(lbl, prop)
`define JSU_NEVER(lbl, expr)
`endif

`endif

>>> design/jsu_pkg.sv
// types, constants and helpers for the json string unescape block
// no dependencies
`timescale 1ns / 1ps

package jsu_pkg;

  localparam int COUNT_BITS = 12;
  localparam int CFG_W      = 12;
  localparam int SUM_W      = ((COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W) + 1;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
  localparam logic [CFG_W-1:0] MAX_BYTES_RST = '1;

  localparam int ADDR_W = 3;
  localparam logic REG_MAX_VALUE_BYTES = 1'b0;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_UNTERM    = 3'd1;
  localparam logic [2:0] ST_TRAIL_ESC = 3'd2;
  localparam logic [2:0] ST_BAD_ESC   = 3'd3;
  localparam logic [2:0] ST_CTRL      = 3'd4;
  localparam logic [2:0] ST_BAD_HEX   = 3'd5;
  localparam logic [2:0] ST_OVERFLOW  = 3'd6;

  // characters
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CTRL_LIMIT = 8'h20;

  // utf-8 framing
  localparam logic [7:0] UTF8_CONT  = 8'h80;
  localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
  localparam logic [7:0] UTF8_LEAD3 = 8'hE0;

  typedef enum logic [6:0] {
    MODE_IDLE = 7'b0000001,
    MODE_TEXT = 7'b0000010,
    MODE_ESC  = 7'b0000100,
    MODE_HEX0 = 7'b0001000,
    MODE_HEX1 = 7'b0010000,
    MODE_HEX2 = 7'b0100000,
    MODE_HEX3 = 7'b1000000
  } mode_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       value_done;
    logic [2:0] status;
    logic       last;
  } res_t;

  typedef struct packed {
    res_t [2:0] res;
    logic [1:0] n;
  } dec_out_t;

  // returns {valid, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [7:0] d;
    logic       ok;
    d  = 8'h00;
    ok = 1'b0;
    case (c) inside
      [8'h30:8'h39]: begin
        d  = c - 8'h30;
        ok = 1'b1;
      end
      [8'h61:8'h66]: begin
        d  = c - 8'h57;
        ok = 1'b1;
      end
      [8'h41:8'h46]: begin
        d  = c - 8'h37;
        ok = 1'b1;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
    return {ok, d[3:0]};
  endfunction

endpackage

>>> design/jsu_decoder.sv
// per-byte decoder: mode, hex and byte count state, up to three results per item
// depends on jsu_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module jsu_decoder (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          acc,
  input  logic [7:0]                    data_byte,
  input  logic                          value_start,
  input  logic                          text_end,
  input  logic [jsu_pkg::CFG_W-1:0]     max_value_bytes,
  output jsu_pkg::dec_out_t             dec
);

  jsu_pkg::mode_t                    mode_r, mode_nxt, mode_e;
  logic [11:0]                       hex_r, hex_nxt, hex_e;
  logic [jsu_pkg::COUNT_BITS-1:0]    bw_r, bw_nxt, bw_e;

  logic                              fin;
  logic [2:0]                        fin_st;
  logic [1:0]                        ecnt;
  logic [7:0]                        eb0, eb1, eb2;
  logic [4:0]                        hx;
  logic [15:0]                       code;
  logic [jsu_pkg::SUM_W-1:0]         sum, limit, lim_cfg, lim_cnt;

  assign hx   = jsu_pkg::hex_digit(data_byte);
  assign code = {hex_e, hx[3:0]};

  always_comb begin
    mode_e = value_start ? jsu_pkg::MODE_TEXT : mode_r;
    hex_e  = value_start ? 12'd0 : hex_r;
    bw_e   = value_start ? '0 : bw_r;

    mode_nxt = mode_e;
    hex_nxt  = hex_e;
    bw_nxt   = bw_e;
    fin      = 1'b0;
    fin_st   = jsu_pkg::ST_OK;
    ecnt     = 2'd0;
    eb0      = 8'h00;
    eb1      = 8'h00;
    eb2      = 8'h00;

    if (mode_e != jsu_pkg::MODE_IDLE && text_end) begin
      fin = 1'b1;
      case (mode_e)
        jsu_pkg::MODE_TEXT: fin_st = jsu_pkg::ST_UNTERM;
        jsu_pkg::MODE_ESC:  fin_st = jsu_pkg::ST_TRAIL_ESC;
        default:            fin_st = jsu_pkg::ST_BAD_HEX;
      endcase
    end else begin
      case (mode_e)
        jsu_pkg::MODE_IDLE: begin
          fin = 1'b0;
        end
        jsu_pkg::MODE_TEXT: begin
          if (data_byte == jsu_pkg::CH_QUOTE) begin
            fin    = 1'b1;
            fin_st = jsu_pkg::ST_OK;
          end else if (data_byte == jsu_pkg::CH_BSLASH) begin
            mode_nxt = jsu_pkg::MODE_ESC;
          end else if (data_byte < jsu_pkg::CTRL_LIMIT) begin
            fin    = 1'b1;
            fin_st = jsu_pkg::ST_CTRL;
          end else begin
            ecnt = 2'd1;
            eb0  = data_byte;
          end
        end
        jsu_pkg::MODE_ESC: begin
          mode_nxt = jsu_pkg::MODE_TEXT;
          ecnt     = 2'd1;
          case (data_byte)
            jsu_pkg::CH_QUOTE:  eb0 = jsu_pkg::CH_QUOTE;
            jsu_pkg::CH_BSLASH: eb0 = jsu_pkg::CH_BSLASH;
            jsu_pkg::CH_SLASH:  eb0 = jsu_pkg::CH_SLASH;
            jsu_pkg::CH_B:      eb0 = jsu_pkg::CH_BS;
            jsu_pkg::CH_F:      eb0 = jsu_pkg::CH_FF;
            jsu_pkg::CH_N:      eb0 = jsu_pkg::CH_LF;
            jsu_pkg::CH_R:      eb0 = jsu_pkg::CH_CR;
            jsu_pkg::CH_T:      eb0 = jsu_pkg::CH_TAB;
            jsu_pkg::CH_U: begin
              ecnt     = 2'd0;
              mode_nxt = jsu_pkg::MODE_HEX0;
              hex_nxt  = 12'd0;
            end
            default: begin
              ecnt   = 2'd0;
              fin    = 1'b1;
              fin_st = jsu_pkg::ST_BAD_ESC;
            end
          endcase
        end
        default: begin
          if (!hx[4]) begin
            fin    = 1'b1;
            fin_st = jsu_pkg::ST_BAD_HEX;
          end else if (mode_e == jsu_pkg::MODE_HEX3) begin
            hex_nxt  = 12'd0;
            mode_nxt = jsu_pkg::MODE_TEXT;
            if (code < 16'h0080) begin
              ecnt = 2'd1;
              eb0  = code[7:0];
            end else if (code < 16'h0800) begin
              ecnt = 2'd2;
              eb0  = jsu_pkg::UTF8_LEAD2 | {3'b000, code[10:6]};
              eb1  = jsu_pkg::UTF8_CONT | {2'b00, code[5:0]};
            end else begin
              ecnt = 2'd3;
              eb0  = jsu_pkg::UTF8_LEAD3 | {4'b0000, code[15:12]};
              eb1  = jsu_pkg::UTF8_CONT | {2'b00, code[11:6]};
              eb2  = jsu_pkg::UTF8_CONT | {2'b00, code[5:0]};
            end
          end else begin
            hex_nxt = {hex_e[7:0], hx[3:0]};
            case (mode_e)
              jsu_pkg::MODE_HEX0: mode_nxt = jsu_pkg::MODE_HEX1;
              jsu_pkg::MODE_HEX1: mode_nxt = jsu_pkg::MODE_HEX2;
              default:            mode_nxt = jsu_pkg::MODE_HEX3;
            endcase
          end
        end
      endcase
    end

    // byte limit check
    sum     = jsu_pkg::SUM_W'(bw_e) + jsu_pkg::SUM_W'(ecnt);
    lim_cfg = jsu_pkg::SUM_W'(max_value_bytes);
    lim_cnt = jsu_pkg::SUM_W'(jsu_pkg::CNT_MAX);
    limit   = (lim_cfg < lim_cnt) ? lim_cfg : lim_cnt;
    if (ecnt != 2'd0 && sum > limit) begin
      fin    = 1'b1;
      fin_st = jsu_pkg::ST_OVERFLOW;
    end

    dec = '0;
    if (fin) begin
      mode_nxt               = jsu_pkg::MODE_IDLE;
      hex_nxt                = 12'd0;
      dec.n                  = 2'd1;
      dec.res[0].value_done  = 1'b1;
      dec.res[0].status      = fin_st;
    end else begin
      dec.n = ecnt;
      if (ecnt != 2'd0) begin
        bw_nxt = sum[jsu_pkg::COUNT_BITS-1:0];
      end
      dec.res[0].out_byte   = eb0;
      dec.res[0].byte_valid = 1'b1;
      dec.res[1].out_byte   = eb1;
      dec.res[1].byte_valid = 1'b1;
      dec.res[2].out_byte   = eb2;
      dec.res[2].byte_valid = 1'b1;
    end
    for (int k = 0; k < 3; k++) begin
      dec.res[k].last = (dec.n == 2'(k + 1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= jsu_pkg::MODE_IDLE;
      hex_r  <= 12'd0;
      bw_r   <= '0;
    end else if (acc) begin
      mode_r <= mode_nxt;
      hex_r  <= hex_nxt;
      bw_r   <= bw_nxt;
    end
  end

  `JSU_ASSERT(a_fin_idle, acc && dec.n != 2'd0 && dec.res[0].value_done |=> mode_r == jsu_pkg::MODE_IDLE)
  `JSU_ASSERT(a_multi_no_done, acc && dec.n > 2'd1 |-> !dec.res[0].value_done)
  `JSU_ASSERT(a_count_grows, acc && !value_start |=> bw_r >= $past(bw_r))

endmodule

>>> design/json_string_unescape_utf8_top.sv
// Decodes the body of a JSON string value one raw byte per transaction and
// returns decoded bytes and a finishing status. An input transaction is taken in
// every cycle when it yields at most one result and out_tready stays high; an
// escape that decodes to two or three UTF-8 bytes holds the input while the
// three-entry result buffer drains. A new byte is taken in the cycle the last
// buffered result leaves. The byte limit register answers at addresses 0 to 3
// of the APB-style port, as only the top address bit is decoded.
// depends on jsu_pkg, jsu_decoder and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module json_string_unescape_utf8_top (
  input  logic                        clk,
  input  logic                        rst_n,
  // input stream
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,   // data_byte
  input  logic [0:0]                  in_tuser,   // value_start
  input  logic                        in_tlast,   // text_end
  // result stream
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [7:0]                  out_tdata,  // out_byte
  output logic [4:0]                  out_tuser,  // status[2:0], value_done, byte_valid
  output logic                        out_tlast,  // last_of_run
  // configuration
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [jsu_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);

  logic [jsu_pkg::CFG_W-1:0]  max_bytes_r;
  jsu_pkg::dec_out_t          dec;
  jsu_pkg::res_t [2:0]        buf_r, buf_nxt;
  logic [1:0]                 cnt_r, cnt_nxt;
  logic                       acc, pop, reg_hit;

  // config port
  assign cfg_pready = 1'b1;
  assign reg_hit    = (cfg_paddr[jsu_pkg::ADDR_W-1] == jsu_pkg::REG_MAX_VALUE_BYTES);
  assign cfg_prdata = reg_hit ? {{(32 - jsu_pkg::CFG_W){1'b0}}, max_bytes_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_bytes_r <= jsu_pkg::MAX_BYTES_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && reg_hit) begin
      max_bytes_r <= cfg_pwdata[jsu_pkg::CFG_W-1:0];
    end
  end

  // handshakes
  assign pop       = out_tvalid && out_tready;
  assign in_tready = (cnt_r == 2'd0) || (cnt_r == 2'd1 && out_tready);
  assign acc       = in_tvalid && in_tready;

  jsu_decoder u_dec (
    .clk             (clk),
    .rst_n           (rst_n),
    .acc             (acc),
    .data_byte       (in_tdata),
    .value_start     (in_tuser[0]),
    .text_end        (in_tlast),
    .max_value_bytes (max_bytes_r),
    .dec             (dec)
  );

  // result buffer, head at entry 0
  always_comb begin
    buf_nxt = buf_r;
    cnt_nxt = cnt_r;
    if (acc) begin
      buf_nxt = dec.res;
      cnt_nxt = dec.n;
    end else if (pop) begin
      buf_nxt[0] = buf_r[1];
      buf_nxt[1] = buf_r[2];
      cnt_nxt    = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
  end

  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = buf_r[0].out_byte;
  assign out_tuser  = {buf_r[0].status, buf_r[0].value_done, buf_r[0].byte_valid};
  assign out_tlast  = buf_r[0].last;

  `JSU_ASSERT(a_done_is_last, out_tvalid && buf_r[0].value_done |-> out_tlast && cnt_r == 2'd1)
  `JSU_NEVER(a_byte_and_done, out_tvalid && buf_r[0].byte_valid && buf_r[0].value_done)
  `JSU_ASSERT(a_last_matches_cnt, out_tvalid |-> (out_tlast == (cnt_r == 2'd1)))

endmodule
